// ===== src/gllp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the GIF literal LZW packer.
// Used by the front end, the back end and the top level. No dependencies.
package gllp_pkg;

	localparam logic [1:0] ROLE_SIZE = 2'd0;
	localparam logic [1:0] ROLE_LEN  = 2'd1;
	localparam logic [1:0] ROLE_DATA = 2'd2;
	localparam logic [1:0] ROLE_TERM = 2'd3;

	localparam logic REG_MIN_CODE_SIZE = 1'b0;
	localparam logic REG_PIXEL_COUNT   = 1'b1;

	localparam int CFG_W = 25;

	typedef struct packed {
		logic       start;
		logic [3:0] m;
		logic [7:0] code;
		logic       is_last;
		logic       clr;
	} ctl_t;

	typedef enum logic [1:0] {
		F_RUN,
		F_DIV,
		F_MUL,
		F_PAY
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_SIZE,
		B_ADD,
		B_EMIT,
		B_FLUSH,
		B_TERM
	} back_state_t;

endpackage

// ===== src/gif_literal_lzw_packer_unit.sv =====
`timescale 1ns / 1ps
// GIF literal LZW packer top level: configuration registers, front end, command
// queue and back end. Depends on gllp_pkg, gllp_front, gllp_queue and gllp_back.
// A pixel inside a frame is queued on acceptance, one per cycle until the queue fills.
// The back end takes a command, emits the size byte at frame start, adds each code to
// the bit accumulator, emits each output byte and, at frame end, flushes any pending
// bits; it emits at most one byte per cycle. The first pixel of a frame holds off the
// input while the serial divider and the multiplier size the payload. Reset clears
// all control state; min_code_size resets to 2 and pixel_count to 1.
module gif_literal_lzw_packer_unit #(
	parameter int PIXEL_COUNT_BITS = 24,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [7:0]                 s_tdata,    // pixel_index
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [7:0]                 m_tdata,    // out_byte
	output logic [1:0]                 m_tuser,    // byte_role
	output logic                       m_tlast,    // last_byte
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [gllp_pkg::CFG_W-1:0] cfg_data
);
	import gllp_pkg::*;

	localparam int PAY_W = PIXEL_COUNT_BITS + 2;
	localparam int QW    = $bits(ctl_t) + PAY_W;

	logic [3:0]       min_code_size_q;
	logic [CFG_W-1:0] pixel_count_q;
	logic             q_full;
	logic             q_empty;
	logic             q_push;
	logic             q_pop;
	ctl_t             push_ctl;
	logic [PAY_W-1:0] push_pay;
	ctl_t             rd_ctl;
	logic [PAY_W-1:0] rd_pay;
	logic [QW-1:0]    rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_code_size_q <= 4'd2;
			pixel_count_q   <= CFG_W'(1);
		end else if (cfg_we) begin
			if (cfg_index == REG_MIN_CODE_SIZE) begin
				min_code_size_q <= cfg_data[3:0];
			end else if (cfg_index == REG_PIXEL_COUNT) begin
				pixel_count_q <= cfg_data;
			end
		end
	end

	gllp_front #(
		.PIXEL_COUNT_BITS(PIXEL_COUNT_BITS),
		.PAY_W(PAY_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.cfg_m(min_code_size_q),
		.cfg_n(pixel_count_q),
		.q_full(q_full),
		.push(q_push),
		.push_ctl(push_ctl),
		.push_pay(push_pay)
	);

	gllp_queue #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.wr_data({push_ctl, push_pay}),
		.pop(q_pop),
		.rd_data(rd_data),
		.full(q_full),
		.empty(q_empty)
	);

	assign {rd_ctl, rd_pay} = rd_data;

	gllp_back #(
		.PAY_W(PAY_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.pop(q_pop),
		.q_ctl(rd_ctl),
		.q_pay(rd_pay),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

endmodule

// ===== src/gllp_queue.sv =====
`timescale 1ns / 1ps
// Short register queue between the front end and the back end.
// Generic width and depth; no package dependency.
module gllp_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/gllp_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts pixel transactions, sizes the frame payload at frame start
// and queues one classified command per pixel. Depends on gllp_pkg.
module gllp_front #(
	parameter int PIXEL_COUNT_BITS = 24,
	parameter int PAY_W = PIXEL_COUNT_BITS + 2
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [7:0]                s_tdata,   // pixel_index
	input  logic [3:0]                cfg_m,
	input  logic [gllp_pkg::CFG_W-1:0] cfg_n,
	input  logic                      q_full,
	output logic                      push,
	output gllp_pkg::ctl_t            push_ctl,
	output logic [PAY_W-1:0]          push_pay
);
	import gllp_pkg::*;

	localparam int PCB    = PIXEL_COUNT_BITS;
	localparam int CNT_W  = PCB + 1;
	localparam int EXT_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int SUM_W  = CNT_W + 1;
	localparam int PROD_W = SUM_W + 4;
	localparam int DCW    = $clog2(PCB);

	front_state_t     state_q, state_d;
	logic [3:0]       frame_m_q;
	logic [CNT_W-1:0] frame_n_q;
	logic [7:0]       run_q;
	logic [7:0]       code_hold_q;
	logic [CNT_W-1:0] pixels_taken_q;
	logic [7:0]       literal_run_q;
	logic [PCB-1:0]   dvd_q;
	logic [PCB-1:0]   quo_q;
	logic [7:0]       rem_q;
	logic [DCW-1:0]   div_cnt_q;
	logic [PROD_W-1:0] bits_q;

	logic             accept;
	logic             start_take;
	logic             div_step;
	logic             mul_step;
	logic             start_push;
	logic [3:0]       m_clamp;
	logic [EXT_W-1:0] n_ext;
	logic [CNT_W-1:0] n_clamp;
	logic [8:0]       rem_sh;
	logic             rem_ge;
	logic [CNT_W:0]   taken_inc;
	logic [8:0]       lit_inc;
	logic             px_last;
	logic             px_clr;
	logic [7:0]       code_mask;
	logic [7:0]       code_raw;
	logic [SUM_W-1:0] sum;
	logic [PROD_W-1:0] bits_rnd;

	always_comb begin
		if (cfg_m < 4'd2) begin
			m_clamp = 4'd2;
		end else if (cfg_m > 4'd8) begin
			m_clamp = 4'd8;
		end else begin
			m_clamp = cfg_m;
		end
		n_ext = EXT_W'(cfg_n);
		if (n_ext == '0) begin
			n_ext = EXT_W'(1);
		end else if (n_ext > (EXT_W'(1) << PCB)) begin
			n_ext = EXT_W'(1) << PCB;
		end
		n_clamp = CNT_W'(n_ext);
	end

	assign rem_sh    = {rem_q, dvd_q[PCB-1]};
	assign rem_ge    = (rem_sh >= {1'b0, run_q});
	assign taken_inc = {1'b0, pixels_taken_q} + 1'b1;
	assign lit_inc   = {1'b0, literal_run_q} + 1'b1;
	assign px_last   = (taken_inc >= {1'b0, frame_n_q});
	assign px_clr    = !px_last && (lit_inc >= {1'b0, run_q});
	assign code_mask = 8'(8'hFF >> (4'd8 - frame_m_q));
	assign code_raw  = start_push ? code_hold_q : s_tdata;
	assign sum       = SUM_W'(frame_n_q) + SUM_W'(quo_q) + SUM_W'(2);
	assign bits_rnd  = bits_q + PROD_W'(7);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_RUN: begin
				if (accept && pixels_taken_q == '0) begin
					state_d = F_DIV;
				end
			end
			F_DIV: begin
				if (div_cnt_q == DCW'(PCB - 1)) begin
					state_d = F_MUL;
				end
			end
			F_MUL: state_d = F_PAY;
			F_PAY: state_d = F_RUN;
			default: state_d = F_RUN;
		endcase
	end

	always_comb begin
		s_tready   = 1'b0;
		div_step   = 1'b0;
		mul_step   = 1'b0;
		start_push = 1'b0;
		unique case (state_q)
			F_RUN: s_tready = !q_full;
			F_DIV: div_step = 1'b1;
			F_MUL: mul_step = 1'b1;
			F_PAY: start_push = 1'b1;
			default: s_tready = 1'b0;
		endcase
	end

	assign accept     = s_tvalid && s_tready;
	assign start_take = accept && (pixels_taken_q == '0);
	assign push       = (accept && (pixels_taken_q != '0)) || start_push;

	always_comb begin
		push_ctl.start   = start_push;
		push_ctl.m       = frame_m_q;
		push_ctl.code    = code_raw & code_mask;
		push_ctl.is_last = px_last;
		push_ctl.clr     = px_clr;
		push_pay         = PAY_W'(bits_rnd >> 3);
	end

	always_ff @(posedge clk) begin
		if (start_take) begin
			code_hold_q <= s_tdata;
			dvd_q       <= PCB'(n_clamp - 1'b1);
			quo_q       <= '0;
			rem_q       <= '0;
		end else if (div_step) begin
			dvd_q <= {dvd_q[PCB-2:0], 1'b0};
			quo_q <= {quo_q[PCB-2:0], rem_ge};
			rem_q <= rem_ge ? 8'(rem_sh - {1'b0, run_q}) : rem_sh[7:0];
		end
		if (mul_step) begin
			bits_q <= PROD_W'(sum) * PROD_W'({1'b0, frame_m_q} + 5'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= F_RUN;
			frame_m_q      <= 4'd2;
			frame_n_q      <= CNT_W'(1);
			run_q          <= 8'd2;
			pixels_taken_q <= '0;
			literal_run_q  <= '0;
			div_cnt_q      <= '0;
		end else begin
			state_q <= state_d;
			if (start_take) begin
				frame_m_q <= m_clamp;
				frame_n_q <= n_clamp;
				run_q     <= 8'((9'd1 << m_clamp) - 9'd2);
				div_cnt_q <= '0;
			end else if (div_step) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			if (push) begin
				if (px_last) begin
					pixels_taken_q <= '0;
					literal_run_q  <= '0;
				end else begin
					pixels_taken_q <= taken_inc[CNT_W-1:0];
					literal_run_q  <= px_clr ? 8'd0 : lit_inc[7:0];
				end
			end
		end
	end

endmodule

// ===== src/gllp_back.sv =====
`timescale 1ns / 1ps
// Back end: turns queued commands into codes, packs them LSB first into bytes,
// frames sub-blocks and drives the output register. Depends on gllp_pkg.
module gllp_back #(
	parameter int PAY_W = 26
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	output logic             pop,
	input  gllp_pkg::ctl_t   q_ctl,
	input  logic [PAY_W-1:0] q_pay,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,   // out_byte
	output logic [1:0]       m_tuser,   // byte_role
	output logic             m_tlast    // last_byte
);
	import gllp_pkg::*;

	localparam logic [1:0] PH_START = 2'd0;
	localparam logic [1:0] PH_LIT   = 2'd1;
	localparam logic [1:0] PH_TAIL  = 2'd2;

	back_state_t      state_q, state_d;
	ctl_t             ctl_q;
	logic [1:0]       phase_q, phase_d;
	logic [15:0]      acc_q, acc_d;
	logic [4:0]       cnt_q, cnt_d;
	logic [7:0]       block_q, block_d;
	logic [PAY_W-1:0] pay_q, pay_d;
	logic             out_valid_q;
	logic [7:0]       out_data_q;
	logic [1:0]       out_role_q;
	logic             out_last_q;

	logic             adv;
	logic             emit;
	logic [7:0]       emit_byte;
	logic [1:0]       emit_role;
	logic             emit_last;
	logic [3:0]       w;
	logic [8:0]       clear9;
	logic [8:0]       code_cur;
	logic [15:0]      acc_add;
	logic [4:0]       cnt_add;
	logic [4:0]       cnt_rem;
	logic             has2;
	logic             phase_more;
	logic [1:0]       nrem;
	logic [5:0]       tail_bits;
	logic [5:0]       size_bits;
	logic             data_last;
	logic             size_last;
	logic [7:0]       len_val;
	logic [PAY_W-1:0] pay_dec;

	assign adv      = !out_valid_q || m_tready;
	assign w        = ctl_q.m + 4'd1;
	assign clear9   = 9'd1 << ctl_q.m;
	assign has2     = ctl_q.is_last || ctl_q.clr;
	assign cnt_add  = cnt_q + 5'(w);
	assign cnt_rem  = cnt_q - 5'd8;
	assign acc_add  = acc_q | (16'(code_cur) << cnt_q);
	assign pay_dec  = (pay_q != '0) ? pay_q - 1'b1 : pay_q;
	assign len_val  = (pay_q > PAY_W'(255)) ? 8'hFF :
	                  ((pay_q == '0) ? 8'd1 : pay_q[7:0]);
	assign phase_more = (phase_q == PH_START) || (phase_q == PH_LIT && has2);
	assign tail_bits  = 6'(cnt_rem) + 6'(nrem) * 6'(w);
	assign size_bits  = 6'(w) * (6'd2 + 6'(ctl_q.clr));
	assign data_last  = !ctl_q.is_last && (tail_bits < 6'd8);
	assign size_last  = !ctl_q.is_last && (size_bits < 6'd8);

	always_comb begin
		case (phase_q)
			PH_START: code_cur = clear9;
			PH_LIT:   code_cur = {1'b0, ctl_q.code};
			default:  code_cur = ctl_q.is_last ? clear9 + 9'd1 : clear9;
		endcase
		case (phase_q)
			PH_START: nrem = 2'd1 + 2'(has2);
			PH_LIT:   nrem = 2'(has2);
			default:  nrem = 2'd0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					state_d = q_ctl.start ? B_SIZE : B_ADD;
				end
			end
			B_SIZE: begin
				if (adv) begin
					state_d = B_ADD;
				end
			end
			B_ADD: begin
				if (cnt_add >= 5'd8) begin
					state_d = B_EMIT;
				end else if (phase_more) begin
					state_d = B_ADD;
				end else if (ctl_q.is_last) begin
					state_d = B_FLUSH;
				end else begin
					state_d = B_IDLE;
				end
			end
			B_EMIT: begin
				if (adv && block_q != 8'd0 && cnt_rem < 5'd8) begin
					if (phase_more) begin
						state_d = B_ADD;
					end else if (ctl_q.is_last) begin
						state_d = B_FLUSH;
					end else begin
						state_d = B_IDLE;
					end
				end
			end
			B_FLUSH: begin
				if (cnt_q == 5'd0) begin
					state_d = B_TERM;
				end else if (adv && block_q != 8'd0) begin
					state_d = B_TERM;
				end
			end
			B_TERM: begin
				if (adv) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		emit      = 1'b0;
		emit_byte = 8'd0;
		emit_role = ROLE_DATA;
		emit_last = 1'b0;
		phase_d   = phase_q;
		acc_d     = acc_q;
		cnt_d     = cnt_q;
		block_d   = block_q;
		pay_d     = pay_q;
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					pop = 1'b1;
					if (q_ctl.start) begin
						phase_d = PH_START;
						acc_d   = '0;
						cnt_d   = '0;
						block_d = '0;
						pay_d   = q_pay;
					end else begin
						phase_d = PH_LIT;
					end
				end
			end
			B_SIZE: begin
				if (adv) begin
					emit      = 1'b1;
					emit_byte = {4'd0, ctl_q.m};
					emit_role = ROLE_SIZE;
					emit_last = size_last;
				end
			end
			B_ADD: begin
				acc_d = acc_add;
				cnt_d = cnt_add;
				if (cnt_add < 5'd8 && phase_more) begin
					phase_d = phase_q + 2'd1;
				end
			end
			B_EMIT: begin
				if (adv) begin
					emit = 1'b1;
					if (block_q == 8'd0) begin
						emit_byte = len_val;
						emit_role = ROLE_LEN;
						block_d   = len_val;
					end else begin
						emit_byte = acc_q[7:0];
						emit_role = ROLE_DATA;
						emit_last = (cnt_rem < 5'd8) && data_last;
						acc_d     = acc_q >> 8;
						cnt_d     = cnt_rem;
						block_d   = block_q - 8'd1;
						pay_d     = pay_dec;
						if (cnt_rem < 5'd8 && phase_more) begin
							phase_d = phase_q + 2'd1;
						end
					end
				end
			end
			B_FLUSH: begin
				if (cnt_q != 5'd0 && adv) begin
					emit = 1'b1;
					if (block_q == 8'd0) begin
						emit_byte = len_val;
						emit_role = ROLE_LEN;
						block_d   = len_val;
					end else begin
						emit_byte = acc_q[7:0];
						emit_role = ROLE_DATA;
						cnt_d     = '0;
						block_d   = block_q - 8'd1;
						pay_d     = pay_dec;
					end
				end
			end
			B_TERM: begin
				if (adv) begin
					emit      = 1'b1;
					emit_byte = 8'd0;
					emit_role = ROLE_TERM;
					emit_last = 1'b1;
					acc_d     = '0;
					cnt_d     = '0;
					block_d   = '0;
					pay_d     = '0;
				end
			end
			default: pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ctl_q <= q_ctl;
		end
		if (emit) begin
			out_data_q <= emit_byte;
			out_role_q <= emit_role;
			out_last_q <= emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			phase_q     <= PH_LIT;
			acc_q       <= '0;
			cnt_q       <= '0;
			block_q     <= '0;
			pay_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			acc_q   <= acc_d;
			cnt_q   <= cnt_d;
			block_q <= block_d;
			pay_q   <= pay_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_role_q;
	assign m_tlast  = out_last_q;

endmodule
